// ----- hw/rtl/binary_scan_frame_deframer_unit_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef BINARY_SCAN_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define BINARY_SCAN_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge; quiet while reset is asserted.
`define BSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define BSFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BSFD_ASSERT(lbl, prop, msg)
`define BSFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/bsfd_pkg.sv -----
// Types, codes and helpers of the binary scan frame deframer.
`default_nettype none

package bsfd_pkg;

  // Frame parser state, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_RECORDS = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Input request operation (carried on tuser).
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EXP_MASK   = 2'd0;
  localparam logic [1:0] CFG_EXP_POINTS = 2'd1;
  localparam logic [1:0] CFG_PROBE      = 2'd2;

  localparam logic [15:0] EXP_MASK_RST = 16'h0087;

  // Mask bits selecting record contents.
  localparam int unsigned MASK_FREQ = 0;
  localparam int unsigned MASK_S11  = 1;
  localparam int unsigned MASK_S21  = 2;

  localparam int unsigned OUT_W = 192;

  // Replace byte lane 'lane' of a 32-bit word.
  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                           logic [7:0] b);
    logic [31:0] res;
    res = word;
    unique case (lane)
      2'd0: res[7:0]   = b;
      2'd1: res[15:8]  = b;
      2'd2: res[23:16] = b;
      default: res[31:24] = b;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/binary_scan_frame_deframer_unit.sv -----
// Binary scan reply deframer: byte stream in, point/status results out.
//
// Usage:
//   Slave stream: one request per reply byte. tuser = operation (0 data
//   byte, 1 arm for a new frame), tdata[7:0] = byte. An arm abandons any
//   frame in progress and waits for the 4-byte little-endian header
//   (mask, point count), which is compared with the configured request.
//   Master stream: at most one result per input request. tuser = result
//   kind (0 point, 1 frame done, 2 header mismatch), tlast ends the frame.
//   After a mismatch, bytes are dropped until the next arm.
//   Config port: cfg_we_i writes register cfg_index_i (0 expected mask,
//   1 expected points, 2 probe mode) with cfg_data_i; write only while idle.
// Timing:
//   A request waits in the input register, then parse logic writes its
//   result into the output register. Throughput 1 byte per cycle unless a
//   waiting result stalls the output.
// Reset: parser idle, bytes ignored until the first arm; registers take
//   mask 0x87, points 0, probe off.
// Stall: a result waits in the output register; the input register holds
//   one more byte, then s_axis_tready drops until the receiver takes it.
`default_nettype none

`include "binary_scan_frame_deframer_unit_defines.svh"

module binary_scan_frame_deframer_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave byte stream
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  wire logic         s_axis_tuser,   // [0] operation
  // master result stream
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] freq_hz, [63:32] s11_re_bits, [95:64] s11_im_bits,
  // [127:96] s21_re_bits, [159:128] s21_im_bits,
  // [175:160] got_mask, [191:176] got_points
  output      logic [bsfd_pkg::OUT_W-1:0] m_axis_tdata,
  output      logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  output      logic         m_axis_tlast,   // last
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [15:0] exp_mask_q, exp_points_q;
  logic        probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_mask_q   <= bsfd_pkg::EXP_MASK_RST;
      exp_points_q <= '0;
      probe_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsfd_pkg::CFG_EXP_MASK:   exp_mask_q   <= cfg_data_i;
        bsfd_pkg::CFG_EXP_POINTS: exp_points_q <= cfg_data_i;
        bsfd_pkg::CFG_PROBE:      probe_q      <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;   // parse stage may hand over its request
  logic       proc;      // a request is parsed this cycle

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // ----------------------------------------------------------- frame state
  bsfd_pkg::phase_e phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] hdr_q, hdr_d;
  logic [15:0] pts_q, pts_d;
  logic [31:0] freq_q, freq_d;
  logic [31:0] s11_re_q, s11_re_d, s11_im_q, s11_im_d;
  logic [31:0] s21_re_q, s21_re_d, s21_im_q, s21_im_d;

  logic [4:0]  rec_size;
  logic [4:0]  pos_a, pos_b;   // record offset past freq, past S11
  logic [31:0] hdr_full;
  logic        emit, with_data, last_d;
  bsfd_pkg::kind_e kind_d;

  // Record length in bytes from the received mask.
  assign rec_size = (hdr_q[bsfd_pkg::MASK_FREQ] ? 5'd4 : 5'd0)
                  + (hdr_q[bsfd_pkg::MASK_S11]  ? 5'd8 : 5'd0)
                  + (hdr_q[bsfd_pkg::MASK_S21]  ? 5'd8 : 5'd0);
  assign pos_a    = hdr_q[bsfd_pkg::MASK_FREQ] ? idx_q - 5'd4 : idx_q;
  assign pos_b    = hdr_q[bsfd_pkg::MASK_S11]  ? pos_a - 5'd8 : pos_a;
  assign hdr_full = {in_byte_q, hdr_q[23:0]};

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    hdr_d     = hdr_q;
    pts_d     = pts_q;
    freq_d    = freq_q;
    s11_re_d  = s11_re_q;
    s11_im_d  = s11_im_q;
    s21_re_d  = s21_re_q;
    s21_im_d  = s21_im_q;
    emit      = 1'b0;
    with_data = 1'b0;
    last_d    = 1'b0;
    kind_d    = bsfd_pkg::KIND_POINT;

    if (proc) begin
      if (in_op_q == bsfd_pkg::OP_ARM) begin
        phase_d  = bsfd_pkg::PH_HEADER;
        idx_d    = '0;
        hdr_d    = '0;
        pts_d    = '0;
        freq_d   = '0;
        s11_re_d = '0;
        s11_im_d = '0;
        s21_re_d = '0;
        s21_im_d = '0;
      end else begin
        unique case (phase_q)
          bsfd_pkg::PH_HEADER: begin
            hdr_d = bsfd_pkg::put_byte(hdr_q, idx_q[1:0], in_byte_q);
            if (idx_q == 5'd3) begin
              idx_d  = '0;
              emit   = 1'b1;
              last_d = 1'b1;
              if (hdr_full[15:0] != exp_mask_q || hdr_full[31:16] != exp_points_q) begin
                phase_d = bsfd_pkg::PH_DISCARD;
                kind_d  = bsfd_pkg::KIND_ERROR;
              end else if (hdr_full[31:16] == 16'd0 || hdr_full[2:0] == 3'd0) begin
                // empty frame: nothing to parse
                phase_d = bsfd_pkg::PH_IDLE;
                kind_d  = bsfd_pkg::KIND_DONE;
              end else begin
                phase_d = bsfd_pkg::PH_RECORDS;
                pts_d   = hdr_full[31:16];
                emit    = 1'b0;
                last_d  = 1'b0;
              end
            end else begin
              idx_d = idx_q + 5'd1;
            end
          end
          bsfd_pkg::PH_RECORDS: begin
            // route the byte to its word by record offset
            if (hdr_q[bsfd_pkg::MASK_FREQ] && idx_q < 5'd4) begin
              freq_d = bsfd_pkg::put_byte(freq_q, idx_q[1:0], in_byte_q);
            end else if (hdr_q[bsfd_pkg::MASK_S11] && pos_a < 5'd8) begin
              if (pos_a[2]) s11_im_d = bsfd_pkg::put_byte(s11_im_q, idx_q[1:0], in_byte_q);
              else          s11_re_d = bsfd_pkg::put_byte(s11_re_q, idx_q[1:0], in_byte_q);
            end else if (hdr_q[bsfd_pkg::MASK_S21] && pos_b < 5'd8) begin
              if (pos_b[2]) s21_im_d = bsfd_pkg::put_byte(s21_im_q, idx_q[1:0], in_byte_q);
              else          s21_re_d = bsfd_pkg::put_byte(s21_re_q, idx_q[1:0], in_byte_q);
            end

            if (idx_q + 5'd1 == rec_size) begin
              idx_d = '0;
              pts_d = pts_q - 16'd1;
              if (pts_d == 16'd0) begin
                phase_d   = bsfd_pkg::PH_IDLE;
                emit      = 1'b1;
                last_d    = 1'b1;
                if (probe_q) kind_d = bsfd_pkg::KIND_DONE;
                with_data = !probe_q;
              end else if (!probe_q) begin
                emit      = 1'b1;
                with_data = 1'b1;
              end
            end else begin
              idx_d = idx_q + 5'd1;
            end
          end
          default: ;  // idle or discarding: byte dropped
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bsfd_pkg::PH_IDLE;
      idx_q    <= '0;
      hdr_q    <= '0;
      pts_q    <= '0;
      freq_q   <= '0;
      s11_re_q <= '0;
      s11_im_q <= '0;
      s21_re_q <= '0;
      s21_im_q <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      hdr_q    <= hdr_d;
      pts_q    <= pts_d;
      freq_q   <= freq_d;
      s11_re_q <= s11_re_d;
      s11_im_q <= s11_im_d;
      s21_re_q <= s21_re_d;
      s21_im_q <= s21_im_d;
    end
  end

  // ---------------------------------------------------------- output stage
  logic [bsfd_pkg::OUT_W-1:0] out_data_q;
  logic [1:0]                 out_kind_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= kind_d;
      out_last_q <= last_d;
      out_data_q <= {hdr_d[31:16], hdr_d[15:0],
                     with_data ? s21_im_d : 32'd0,
                     with_data ? s21_re_d : 32'd0,
                     with_data ? s11_im_d : 32'd0,
                     with_data ? s11_re_d : 32'd0,
                     with_data ? freq_d   : 32'd0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // ------------------------------------------------------------ assertions
  `BSFD_ASSERT(a_hdr_idx,
    phase_q == bsfd_pkg::PH_HEADER |-> idx_q < 5'd4,
    "header index overrun")
  `BSFD_ASSERT(a_rec_idx,
    phase_q == bsfd_pkg::PH_RECORDS |-> (idx_q < rec_size && pts_q != 16'd0),
    "record index or count out of range")
  `BSFD_ASSERT(a_err_discard,
    emit && kind_d == bsfd_pkg::KIND_ERROR |=> phase_q == bsfd_pkg::PH_DISCARD,
    "mismatch did not enter discard")
  `BSFD_ASSERT_ALWAYS(a_status_last,
    out_valid_q && out_kind_q != bsfd_pkg::KIND_POINT |-> out_last_q,
    "status result without last")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the binary scan frame deframer unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int CYCLE_LIMIT  = 500000;  // hard stop, far above the slowest legal run
  localparam int RAND_REQS    = 900;     // live requests in the random part
  localparam int DRAIN_CYCLES = 8;       // settle margin after the last result
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  // One expected result, fields as the master side carries them
  typedef struct packed {
    bsfd_pkg::kind_e kind;
    logic [31:0] freq;
    logic [31:0] s11_re;
    logic [31:0] s11_im;
    logic [31:0] s21_re;
    logic [31:0] s21_im;
    logic        last;
    logic [15:0] got_mask;
    logic [15:0] got_points;
  } scan_result_t;

  // DUT connections, inputs driven to known values from time zero
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         s_axis_tuser  = bsfd_pkg::OP_DATA;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [bsfd_pkg::OUT_W-1:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_index_i   = bsfd_pkg::CFG_EXP_MASK;
  logic [15:0]  cfg_data_i    = '0;

  binary_scan_frame_deframer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer model state (reset values). Only the monitor process touches it.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_mask   = bsfd_pkg::EXP_MASK_RST;
  logic [15:0] cfg_points = '0;
  logic        cfg_probe  = 1'b0;
  bsfd_pkg::phase_e m_phase = bsfd_pkg::PH_IDLE;
  logic [4:0]  m_idx      = '0;
  logic [31:0] hdr_word   = '0;
  logic [15:0] pts_left   = '0;
  logic [31:0] freq_w     = '0;
  logic [31:0] s11_w [2]  = '{32'h0, 32'h0};
  logic [31:0] s21_w [2]  = '{32'h0, 32'h0};

  scan_result_t pending_results [$];

  // Bookkeeping
  int n_errors     = 0;
  int n_reqs       = 0;
  int n_cfg_writes = 0;
  int n_points     = 0;
  int n_done       = 0;
  int n_hdr_errors = 0;
  int cycle_cnt    = 0;
  int live_reqs    = 0;   // requests sent as arms, headers and payload; stray idle bytes excluded

  // Stimulus side copy of the mask and point registers, kept apart from the model
  logic [15:0] cur_mask  = bsfd_pkg::EXP_MASK_RST;
  logic [15:0] cur_pts   = '0;

  // Sender burst control
  int gap_max    = 6;
  int burst_left = 0;

  // Receiver control; a toggle on hold_tok starts a long hold-off
  logic     hold_tok  = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;
  int       rx_tick   = 0;
  rx_mode_e rx_mode   = RX_OPEN;

  // Bytes per record for a given mask
  function automatic int record_bytes(input logic [15:0] mask);
    return (mask[bsfd_pkg::MASK_FREQ] ? 4 : 0) + (mask[bsfd_pkg::MASK_S11] ? 8 : 0)
         + (mask[bsfd_pkg::MASK_S21] ? 8 : 0);
  endfunction

  function automatic scan_result_t make_result(input bsfd_pkg::kind_e kind,
                                               input logic with_data, input logic last);
    scan_result_t r;
    r.kind       = kind;
    r.freq       = with_data ? freq_w   : '0;
    r.s11_re     = with_data ? s11_w[0] : '0;
    r.s11_im     = with_data ? s11_w[1] : '0;
    r.s21_re     = with_data ? s21_w[0] : '0;
    r.s21_im     = with_data ? s21_w[1] : '0;
    r.last       = last;
    r.got_mask   = hdr_word[15:0];
    r.got_points = hdr_word[31:16];
    return r;
  endfunction

  // Advance the model by one accepted request; queue the result it causes, if any
  function automatic void deframe_byte(input logic op, input logic [7:0] b);
    logic [4:0]  pos;
    logic [15:0] hm;
    logic        placed;
    int          sz;
    if (op == bsfd_pkg::OP_ARM) begin
      // arm drops whatever frame was in flight
      m_phase  = bsfd_pkg::PH_HEADER;
      m_idx    = '0;
      hdr_word = '0;
      pts_left = '0;
      freq_w   = '0;
      s11_w    = '{32'h0, 32'h0};
      s21_w    = '{32'h0, 32'h0};
      return;
    end
    case (m_phase)
      bsfd_pkg::PH_HEADER: begin
        hdr_word[8*m_idx[1:0] +: 8] = b;
        m_idx = m_idx + 5'd1;
        if (m_idx == 5'd4) begin
          m_idx = '0;
          hm = hdr_word[15:0];
          if (hm != cfg_mask || hdr_word[31:16] != cfg_points) begin
            m_phase = bsfd_pkg::PH_DISCARD;
            pending_results.push_back(make_result(bsfd_pkg::KIND_ERROR, 1'b0, 1'b1));
          end else if (hdr_word[31:16] == 16'd0 || record_bytes(hm) == 0) begin
            // nothing to read: frame ends right at the header
            m_phase  = bsfd_pkg::PH_IDLE;
            pts_left = '0;
            pending_results.push_back(make_result(bsfd_pkg::KIND_DONE, 1'b0, 1'b1));
          end else begin
            pts_left = hdr_word[31:16];
            m_phase  = bsfd_pkg::PH_RECORDS;
          end
        end
      end
      bsfd_pkg::PH_RECORDS: begin
        hm     = hdr_word[15:0];
        sz     = record_bytes(hm);
        pos    = m_idx;
        placed = 1'b0;
        // record layout: freq (4), S11 re/im (8), S21 re/im (8), present per mask bit
        if (hm[bsfd_pkg::MASK_FREQ]) begin
          if (pos < 5'd4) begin
            freq_w[8*pos[1:0] +: 8] = b;
            placed = 1'b1;
          end else begin
            pos = pos - 5'd4;
          end
        end
        if (!placed && hm[bsfd_pkg::MASK_S11]) begin
          if (pos < 5'd8) begin
            s11_w[pos[2]][8*pos[1:0] +: 8] = b;
            placed = 1'b1;
          end else begin
            pos = pos - 5'd8;
          end
        end
        if (!placed && hm[bsfd_pkg::MASK_S21] && pos < 5'd8) begin
          s21_w[pos[2]][8*pos[1:0] +: 8] = b;
        end
        m_idx = m_idx + 5'd1;
        if (m_idx == 5'(sz)) begin
          m_idx    = '0;
          pts_left = pts_left - 16'd1;
          if (pts_left == 16'd0) begin
            m_phase = bsfd_pkg::PH_IDLE;
            if (cfg_probe) begin
              pending_results.push_back(make_result(bsfd_pkg::KIND_DONE, 1'b0, 1'b1));
            end else begin
              pending_results.push_back(make_result(bsfd_pkg::KIND_POINT, 1'b1, 1'b1));
            end
          end else if (!cfg_probe) begin
            pending_results.push_back(make_result(bsfd_pkg::KIND_POINT, 1'b1, 1'b0));
          end
        end
      end
      default: ;  // idle or discarding: byte dropped
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result, then tracks config writes and
  // accepted requests. A result always trails its request by at least the
  // block latency, so the order inside this block does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    scan_result_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d last %0b", m_axis_tuser, m_axis_tlast);
          n_errors++;
        end else begin
          exp_r = pending_results.pop_front();
          cmp_field("result_kind", 32'(exp_r.kind),       32'(m_axis_tuser));
          cmp_field("freq_hz",     exp_r.freq,            m_axis_tdata[31:0]);
          cmp_field("s11_re_bits", exp_r.s11_re,          m_axis_tdata[63:32]);
          cmp_field("s11_im_bits", exp_r.s11_im,          m_axis_tdata[95:64]);
          cmp_field("s21_re_bits", exp_r.s21_re,          m_axis_tdata[127:96]);
          cmp_field("s21_im_bits", exp_r.s21_im,          m_axis_tdata[159:128]);
          cmp_field("last",        32'(exp_r.last),       32'(m_axis_tlast));
          cmp_field("got_mask",    32'(exp_r.got_mask),   32'(m_axis_tdata[175:160]));
          cmp_field("got_points",  32'(exp_r.got_points), 32'(m_axis_tdata[191:176]));
          case (exp_r.kind)
            bsfd_pkg::KIND_POINT: n_points++;
            bsfd_pkg::KIND_DONE:  n_done++;
            default:              n_hdr_errors++;
          endcase
        end
      end
      if (cfg_we_i) begin
        n_cfg_writes++;
        case (cfg_index_i)
          bsfd_pkg::CFG_EXP_MASK:   cfg_mask   = cfg_data_i;
          bsfd_pkg::CFG_EXP_POINTS: cfg_points = cfg_data_i;
          bsfd_pkg::CFG_PROBE:      cfg_probe  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_reqs++;
        deframe_byte(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rx_tick paces the redraw of the random stall pattern; a toggle
  // of hold_tok forces a tready hold-off; the block backs up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    if (hold_tok != hold_seen) begin
      hold_seen     <= hold_tok;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_cnt, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender helpers. All are entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Bursts of random length
  // keep tvalid high back to back; a random gap opens each burst.
  task automatic send_req(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Byte values skewed toward the all-zero and all-one extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Arm, then the little-endian header (mask, point count)
  task automatic send_hdr(input logic [15:0] mask, input logic [15:0] pts);
    send_req(bsfd_pkg::OP_ARM, rand_byte());
    send_req(bsfd_pkg::OP_DATA, mask[7:0]);
    send_req(bsfd_pkg::OP_DATA, mask[15:8]);
    send_req(bsfd_pkg::OP_DATA, pts[7:0]);
    send_req(bsfd_pkg::OP_DATA, pts[15:8]);
    live_reqs += 5;
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_req(bsfd_pkg::OP_DATA, rand_byte());
    live_reqs += n;
  endtask

  // Park the sender until every expected result is in, then let the
  // pipeline settle (covers requests that produce nothing). The first edge
  // lets the monitor log the last accepted request before the queue is read.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges; only called when drained.
  // Upper data bits on the probe write are junk the block must mask off.
  task automatic set_config(input logic [15:0] mask, input logic [15:0] pts,
                            input logic probe);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= bsfd_pkg::CFG_EXP_MASK;
    cfg_data_i  <= mask;
    @(posedge clk_i);
    cfg_index_i <= bsfd_pkg::CFG_EXP_POINTS;
    cfg_data_i  <= pts;
    @(posedge clk_i);
    cfg_index_i <= bsfd_pkg::CFG_PROBE;
    cfg_data_i  <= {15'($urandom), probe};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mask = mask;
    cur_pts  = pts;
  endtask

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 6))
      0:       return bsfd_pkg::EXP_MASK_RST;
      1:       return 16'($urandom_range(1, 7));
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return {13'($urandom), 3'($urandom_range(1, 7))};
      5:       return 16'($urandom);
      default: return 16'h0007;
    endcase
  endfunction

  // Mostly short frames; the extremes only show up in headers and
  // truncated frames, never as full-length runs.
  function automatic logic [15:0] pick_points();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: stray byte before any arm, zero-count frame, then a
  // mask with no record fields and a nonzero count.
  task automatic test_header_cases();
    send_req(bsfd_pkg::OP_DATA, 8'h5A);         // idle, dropped
    send_hdr(bsfd_pkg::EXP_MASK_RST, 16'd0);    // matches reset registers, done at header
    wait_drained();
    set_config(16'hFFF8, 16'd1, 1'b0);
    send_hdr(16'hFFF8, 16'd1);                  // empty records, done at header
    wait_drained();
  endtask

  // Point-count mismatch, bytes dropped while discarding, then a mask mismatch
  task automatic test_mismatch();
    set_config(16'hFFFF, 16'hFFFF, 1'b0);
    send_hdr(16'hFFFF, 16'hFFFE);
    send_req(bsfd_pkg::OP_DATA, 8'hFF);         // discarded
    send_hdr(16'h0000, 16'hFFFF);
    wait_drained();
  endtask

  // Frequency-only records, with an arm in the middle of a record
  task automatic test_freq_records();
    set_config(16'h0001, 16'd1, 1'b0);
    send_hdr(16'h0001, 16'd1);
    send_req(bsfd_pkg::OP_DATA, 8'hAA);
    send_req(bsfd_pkg::OP_DATA, 8'h55);
    send_hdr(16'h0001, 16'd1);                  // re-arm clears the partial word
    send_req(bsfd_pkg::OP_DATA, 8'hFF);
    send_req(bsfd_pkg::OP_DATA, 8'hFF);
    send_req(bsfd_pkg::OP_DATA, 8'h00);
    send_req(bsfd_pkg::OP_DATA, 8'h00);
    live_reqs += 6;
    wait_drained();
  endtask

  // Probe mode: the single record ends the frame with a done result
  task automatic test_probe();
    set_config(16'h0001, 16'd1, 1'b1);
    send_hdr(16'h0001, 16'd1);
    send_payload(4);
    wait_drained();
  endtask

  // Long receiver hold-off with a sender that never idles, then a sender
  // pause mid-frame until all results are in, then a probe frame with
  // suppressed intermediate records.
  task automatic test_backpressure();
    set_config(16'h0007, 16'd5, 1'b0);
    gap_max = 0;
    hold_tok <= ~hold_tok;
    send_hdr(16'h0007, 16'd5);
    send_payload(5 * 20);
    send_hdr(16'h0007, 16'd5);
    send_payload(2 * 20 + 7);
    wait_drained();                    // pause inside a record
    send_payload(3 * 20 - 7);
    wait_drained();
    set_config(16'h0006, 16'd3, 1'b1);
    send_hdr(16'h0006, 16'd3);
    send_payload(3 * 16);
    wait_drained();
    gap_max = 6;
  endtask

  // Mostly well-formed frames with random content; the rest are header
  // mismatches, truncated frames, garbage after an arm and idle noise.
  task automatic test_random();
    int          start_reqs;
    int          sel;
    int          nrec;
    int          sz;
    logic        first;
    logic [15:0] hm;
    logic [15:0] hp;
    start_reqs = live_reqs;
    first      = 1'b1;
    while (live_reqs - start_reqs < RAND_REQS) begin
      if (first || $urandom_range(0, 5) == 0) begin
        wait_drained();
        set_config(pick_mask(), pick_points(), ($urandom_range(0, 3) == 0));
        case ($urandom_range(0, 3))
          0:       gap_max = 0;
          1:       gap_max = 2;
          2:       gap_max = 8;
          default: gap_max = 16;
        endcase
        first = 1'b0;
      end
      hm  = cur_mask;
      hp  = cur_pts;
      sz  = record_bytes(hm);
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        // well-formed; huge counts get a few records, the next arm cuts them
        send_hdr(hm, hp);
        nrec = (hp <= 16'd6) ? int'(hp) : $urandom_range(1, 4);
        send_payload(nrec * sz);
      end else if (sel < 87) begin
        // single-bit header error in mask or count
        if ($urandom_range(0, 1) == 1) hm ^= 16'(1) << $urandom_range(0, 15);
        else                            hp ^= 16'(1) << $urandom_range(0, 15);
        send_hdr(hm, hp);
        send_payload($urandom_range(0, 6));
      end else if (sel < 94) begin
        // good header, frame cut short somewhere in the records
        send_hdr(hm, hp);
        send_payload($urandom_range(0, 2 * sz));
      end else begin
        // arm followed by a partial or random header
        send_req(bsfd_pkg::OP_ARM, rand_byte());
        live_reqs++;
        send_payload($urandom_range(0, 6));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_req(bsfd_pkg::OP_DATA, rand_byte());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_cases();
    test_mismatch();
    test_freq_records();
    test_probe();
    test_backpressure();
    test_random();

    // tail: everything in, then an idle stretch to catch stray results
    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d requests accepted, %0d register writes, %0d cycles",
             n_reqs, n_cfg_writes, cycle_cnt);
    $display("checked %0d point, %0d frame-done and %0d header-mismatch results",
             n_points, n_done, n_hdr_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
